/* rtl/xcrc_pkg.sv */
package xcrc_pkg;

  localparam int PACKET_BYTES = 128;
  localparam int WORDS        = PACKET_BYTES / 4;
  localparam int WIDX_W       = $clog2(WORDS);
  localparam int CFG_IDX_W    = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TMO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_TMO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TMO_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CANCEL_DLY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_BASE = 3'd5;

  // actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  // characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  // transfer modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RECV = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;

  // output selection
  localparam logic [1:0] SHOW_NONE  = 2'd0;
  localparam logic [1:0] SHOW_WORD  = 2'd1;
  localparam logic [1:0] SHOW_REPLY = 2'd2;
  localparam logic [1:0] SHOW_TAIL  = 2'd3;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  typedef struct packed {
    logic       take;
    logic       rd;
    logic       adv;
    logic [1:0] show;
  } dp_cmd_t;

  typedef struct packed {
    logic burst;
    logic reply;
    logic tail;
    logic word_last;
  } dp_sts_t;

  // CRC-16/XMODEM over one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

/* rtl/xcrc_if.sv */
interface xcrc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       frame_start;
  modport source (output valid, action, data_byte, frame_start, input ready);
  modport sink   (input valid, action, data_byte, frame_start, output ready);
endinterface

interface xcrc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  reply_byte;
  logic [1:0]  reply_repeat;
  logic [31:0] write_address;
  logic [31:0] write_word;
  logic [15:0] packet_count;
  logic        last;
  modport source (output valid, kind, reply_byte, reply_repeat, write_address,
                  write_word, packet_count, last, input ready);
  modport sink   (input valid, kind, reply_byte, reply_repeat, write_address,
                  write_word, packet_count, last, output ready);
endinterface

interface xcrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/xcrc_dp.sv */
module xcrc_dp
  import xcrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  input  logic [1:0]           action,
  input  logic [7:0]           data_byte,
  input  logic                 frame_start,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic [1:0]           kind,
  output logic [7:0]           reply_byte,
  output logic [1:0]           reply_repeat,
  output logic [31:0]          write_address,
  output logic [31:0]          write_word,
  output logic [15:0]          packet_count,
  output logic                 last
);

  // configuration
  logic [15:0] frame_tmo_r, start_tmo_r, cancel_dly_r;
  logic [4:0]  tmo_limit_r;
  logic [3:0]  err_limit_r;
  logic [31:0] flash_base_r;

  // protocol state
  logic [1:0]  mode_r, mode_nxt;
  logic [15:0] tmo_r, tmo_nxt;
  logic [4:0]  tmo_err_r, tmo_err_nxt;
  logic [3:0]  crc_err_r, crc_err_nxt;
  logic [3:0]  seq_err_r, seq_err_nxt;
  logic [7:0]  last_seq_r, last_seq_nxt;
  logic [15:0] pkts_r, pkts_nxt;
  logic [15:0] cancel_r, cancel_nxt;
  logic [7:0]  bidx_r, bidx_nxt;
  logic [7:0]  hseq_r, hseq_nxt;
  logic [7:0]  hcomp_r, hcomp_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crch_r, crch_nxt;

  // result plan
  logic        burst_r, burst_nxt;
  logic        reply_r, reply_nxt;
  logic        tail_r, tail_nxt;
  logic [7:0]  rbyte_r, rbyte_nxt;
  logic [1:0]  rrep_r, rrep_nxt;
  logic [1:0]  tkind_r, tkind_nxt;
  logic [15:0] tcnt_r, tcnt_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [WIDX_W-1:0] widx_r, widx_nxt;

  // packet buffer
  logic [31:0] mem [WORDS];
  logic [31:0] rdata_r;
  logic        mem_we;
  logic [7:0]  boff;

  logic [7:0]  expect_seq;
  logic [15:0] got_crc;
  logic [3:0]  ssum;
  logic [5:0]  tsum;
  logic [15:0] tmo_dec;
  logic [15:0] cc;

  assign expect_seq = last_seq_r + 8'd1;
  assign got_crc    = {crch_r, data_byte};
  assign boff       = bidx_r - 8'd3;

  // work out the next state and the results of one item
  always_comb begin
    mode_nxt     = mode_r;
    tmo_nxt      = tmo_r;
    tmo_err_nxt  = tmo_err_r;
    crc_err_nxt  = crc_err_r;
    seq_err_nxt  = seq_err_r;
    last_seq_nxt = last_seq_r;
    pkts_nxt     = pkts_r;
    cancel_nxt   = cancel_r;
    bidx_nxt     = bidx_r;
    hseq_nxt     = hseq_r;
    hcomp_nxt    = hcomp_r;
    crc_nxt      = crc_r;
    crch_nxt     = crch_r;
    burst_nxt    = burst_r;
    reply_nxt    = reply_r;
    tail_nxt     = tail_r;
    rbyte_nxt    = rbyte_r;
    rrep_nxt     = rrep_r;
    tkind_nxt    = tkind_r;
    tcnt_nxt     = tcnt_r;
    addr_nxt     = addr_r;
    widx_nxt     = widx_r;
    mem_we       = 1'b0;
    ssum         = '0;
    tsum         = '0;
    tmo_dec      = '0;
    cc           = '0;

    if (cmd.adv) begin
      addr_nxt = addr_r + 32'd4;
      widx_nxt = widx_r + WIDX_W'(1);
    end

    if (cmd.take) begin
      burst_nxt = 1'b0;
      reply_nxt = 1'b0;
      tail_nxt  = 1'b0;
      rrep_nxt  = 2'd1;
      tcnt_nxt  = '0;
      case (action)
        ACT_START: begin
          reply_nxt    = 1'b1;
          rbyte_nxt    = CH_C;
          tmo_nxt      = start_tmo_r;
          last_seq_nxt = '0;
          pkts_nxt     = '0;
          bidx_nxt     = '0;
          tmo_err_nxt  = '0;
          crc_err_nxt  = '0;
          seq_err_nxt  = '0;
          mode_nxt     = MODE_RECV;
        end
        ACT_BYTE: begin
          if (mode_r == MODE_RECV) begin
            if (frame_start) begin
              bidx_nxt = '0;
              if (data_byte == CH_SOH) begin
                bidx_nxt = 8'd1;
                crc_nxt  = '0;
              end else begin
                tmo_nxt = frame_tmo_r;
                if (data_byte == CH_EOT) begin
                  mode_nxt  = MODE_DONE;
                  reply_nxt = 1'b1;
                  rbyte_nxt = CH_ACK;
                  tail_nxt  = 1'b1;
                  tkind_nxt = KIND_DONE;
                  tcnt_nxt  = pkts_r;
                end else if (data_byte == CH_CAN) begin
                  reply_nxt = 1'b1;
                  rbyte_nxt = CH_ACK;
                end
              end
            end else if (bidx_r != 8'd0) begin
              bidx_nxt = bidx_r + 8'd1;
              if (bidx_r == 8'd1) begin
                hseq_nxt = data_byte;
              end else if (bidx_r == 8'd2) begin
                hcomp_nxt = data_byte;
              end else if (bidx_r < 8'(3 + PACKET_BYTES)) begin
                mem_we  = 1'b1;
                crc_nxt = crc_byte(crc_r, data_byte);
              end else if (bidx_r == 8'(3 + PACKET_BYTES)) begin
                crch_nxt = data_byte;
              end else begin
                // packet check
                bidx_nxt  = '0;
                tmo_nxt   = frame_tmo_r;
                reply_nxt = 1'b1;
                rbyte_nxt = CH_NAK;
                if (hseq_r == expect_seq && hcomp_r == ~expect_seq) begin
                  if (got_crc == crc_r) begin
                    burst_nxt    = 1'b1;
                    addr_nxt     = flash_base_r + {9'd0, pkts_r, 7'd0};
                    widx_nxt     = '0;
                    pkts_nxt     = pkts_r + 16'd1;
                    last_seq_nxt = expect_seq;
                    rbyte_nxt    = CH_ACK;
                    tmo_err_nxt  = '0;
                    crc_err_nxt  = '0;
                    seq_err_nxt  = '0;
                  end else begin
                    ssum        = crc_err_r + 4'd1;
                    crc_err_nxt = (ssum > err_limit_r) ? err_limit_r : ssum;
                  end
                end else if (hseq_r == last_seq_r && hcomp_r == ~last_seq_r) begin
                  rbyte_nxt   = CH_ACK;
                  tmo_err_nxt = '0;
                  crc_err_nxt = '0;
                  seq_err_nxt = '0;
                end else begin
                  ssum        = seq_err_r + 4'd1;
                  seq_err_nxt = (ssum > err_limit_r) ? err_limit_r : ssum;
                end
                if (seq_err_nxt == err_limit_r || crc_err_nxt == err_limit_r) begin
                  rbyte_nxt  = CH_CAN;
                  rrep_nxt   = 2'd3;
                  cancel_nxt = cancel_dly_r;
                end
              end
            end
          end
        end
        ACT_TICK: begin
          cc = cancel_r;
          if (mode_r == MODE_RECV && tmo_r != 16'd0) begin
            tmo_dec = tmo_r - 16'd1;
            tmo_nxt = tmo_dec;
            if (tmo_dec == 16'd0) begin
              tsum        = {1'b0, tmo_err_r} + 6'd1;
              tmo_err_nxt = (tsum > {1'b0, tmo_limit_r}) ? 5'd0 : tsum[4:0];
              tmo_nxt     = frame_tmo_r;
              reply_nxt   = 1'b1;
              if (tmo_err_nxt == tmo_limit_r) begin
                rbyte_nxt = CH_CAN;
                rrep_nxt  = 2'd3;
                cc        = cancel_dly_r;
                tmo_nxt   = '0;
              end else begin
                rbyte_nxt = CH_NAK;
              end
            end
          end
          // cancel delay runs in any mode
          if (cc != 16'd0) begin
            cc = cc - 16'd1;
            if (cc == 16'd0) begin
              mode_nxt  = MODE_IDLE;
              tail_nxt  = 1'b1;
              tkind_nxt = KIND_ABORT;
            end
          end
          cancel_nxt = cc;
        end
        default: begin
        end
      endcase
    end
  end

  // hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_tmo_r  <= 16'd1000;
      start_tmo_r  <= 16'd3000;
      tmo_limit_r  <= 5'd25;
      err_limit_r  <= 4'd10;
      cancel_dly_r <= 16'd800;
      flash_base_r <= '0;
      mode_r       <= MODE_IDLE;
      tmo_r        <= '0;
      tmo_err_r    <= '0;
      crc_err_r    <= '0;
      seq_err_r    <= '0;
      last_seq_r   <= '0;
      pkts_r       <= '0;
      cancel_r     <= '0;
      bidx_r       <= '0;
      crc_r        <= '0;
      burst_r      <= 1'b0;
      reply_r      <= 1'b0;
      tail_r       <= 1'b0;
      widx_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FRAME_TMO:  frame_tmo_r  <= cfg_data[15:0];
          REG_START_TMO:  start_tmo_r  <= cfg_data[15:0];
          REG_TMO_LIMIT:  tmo_limit_r  <= cfg_data[4:0];
          REG_ERR_LIMIT:  err_limit_r  <= cfg_data[3:0];
          REG_CANCEL_DLY: cancel_dly_r <= cfg_data[15:0];
          REG_FLASH_BASE: flash_base_r <= cfg_data;
          default: begin
          end
        endcase
      end
      mode_r     <= mode_nxt;
      tmo_r      <= tmo_nxt;
      tmo_err_r  <= tmo_err_nxt;
      crc_err_r  <= crc_err_nxt;
      seq_err_r  <= seq_err_nxt;
      last_seq_r <= last_seq_nxt;
      pkts_r     <= pkts_nxt;
      cancel_r   <= cancel_nxt;
      bidx_r     <= bidx_nxt;
      crc_r      <= crc_nxt;
      burst_r    <= burst_nxt;
      reply_r    <= reply_nxt;
      tail_r     <= tail_nxt;
      widx_r     <= widx_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hseq_r  <= hseq_nxt;
    hcomp_r <= hcomp_nxt;
    crch_r  <= crch_nxt;
    rbyte_r <= rbyte_nxt;
    rrep_r  <= rrep_nxt;
    tkind_r <= tkind_nxt;
    tcnt_r  <= tcnt_nxt;
    addr_r  <= addr_nxt;
  end

  // packet buffer: one byte lane written, one word read
  always_ff @(posedge clk) begin
    if (cmd.take && mem_we) begin
      mem[boff[6:2]][boff[1:0]*8 +: 8] <= data_byte;
    end
    if (cmd.rd) begin
      rdata_r <= mem[widx_r];
    end
  end

  assign sts.burst     = burst_r;
  assign sts.reply     = reply_r;
  assign sts.tail      = tail_r;
  assign sts.word_last = (widx_r == WIDX_W'(WORDS - 1));

  // drive the shown result
  always_comb begin
    kind          = KIND_REPLY;
    reply_byte    = '0;
    reply_repeat  = '0;
    write_address = '0;
    write_word    = '0;
    packet_count  = '0;
    last          = 1'b0;
    case (cmd.show)
      SHOW_WORD: begin
        kind          = KIND_WRITE;
        write_address = addr_r;
        write_word    = rdata_r;
      end
      SHOW_REPLY: begin
        reply_byte   = rbyte_r;
        reply_repeat = rrep_r;
        last         = !tail_r;
      end
      SHOW_TAIL: begin
        kind         = tkind_r;
        packet_count = tcnt_r;
        last         = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/xcrc_ctrl.sv */
module xcrc_ctrl
  import xcrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PLAN  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WORD  = 3'd3;
  localparam logic [2:0] S_REPLY = 3'd4;
  localparam logic [2:0] S_TAIL  = 3'd5;

  logic [2:0] state_r, state_nxt;

  // sequence the results of one item
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid) state_nxt = S_PLAN;
      end
      S_PLAN: begin
        if (sts.burst)      state_nxt = S_RD;
        else if (sts.reply) state_nxt = S_REPLY;
        else if (sts.tail)  state_nxt = S_TAIL;
        else                state_nxt = S_IDLE;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_WORD;
      end
      S_WORD: begin
        out_valid = 1'b1;
        cmd.show  = SHOW_WORD;
        if (out_ready) begin
          cmd.adv   = !sts.word_last;
          state_nxt = sts.word_last ? S_REPLY : S_RD;
        end
      end
      S_REPLY: begin
        out_valid = 1'b1;
        cmd.show  = SHOW_REPLY;
        if (out_ready) state_nxt = sts.tail ? S_TAIL : S_IDLE;
      end
      S_TAIL: begin
        out_valid = 1'b1;
        cmd.show  = SHOW_TAIL;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/xmodem_crc_receiver_top.sv */
// Channel  | Dir | Payload                                            | Handshake
// in_ch    | in  | action, data_byte, frame_start                     | valid/ready
// out_ch   | out | kind, reply_byte, reply_repeat, write_address,     | valid/ready
//          |     | write_word, packet_count, last                     |
// cfg_ch   | in  | index, data                                        | valid/ready
//
// An item is accepted, then planned, then each of its results is shown in turn.
// A good packet adds 32 flash writes before the reply, each a buffer read and
// then a show of the word; the buffer read is registered.
// Reset is synchronous, active low; the packet buffer is not cleared.
// A stalled result holds; no new item is taken until the last result goes.
module xmodem_crc_receiver_top
  import xcrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  xcrc_in_if.sink    in_ch,
  xcrc_out_if.source out_ch,
  xcrc_cfg_if.sink   cfg_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  xcrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  xcrc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .action        (in_ch.action),
    .data_byte     (in_ch.data_byte),
    .frame_start   (in_ch.frame_start),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .kind          (out_ch.kind),
    .reply_byte    (out_ch.reply_byte),
    .reply_repeat  (out_ch.reply_repeat),
    .write_address (out_ch.write_address),
    .write_word    (out_ch.write_word),
    .packet_count  (out_ch.packet_count),
    .last          (out_ch.last)
  );

endmodule

/* rtl/xcrc_chk.sv */
module xcrc_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // a shown result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no item is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // the final result frees the input side
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("input not ready after final result");

  // an accepted item is planned before any result shows
  a_plan_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("no planning cycle after accept");

endmodule

bind xmodem_crc_receiver_top xcrc_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last)
);
